// ===== rtl/triac_dimmer_channel_allocator_assert.svh =====
// Assertion macros shared by the allocator modules.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TRIAC_DIMMER_CHANNEL_ALLOCATOR_ASSERT_SVH
`define TRIAC_DIMMER_CHANNEL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define TDCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TDCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/tdca_pkg.sv =====
`timescale 1ns / 1ps
package tdca_pkg;

  localparam int UNITS_DEF   = 3;
  localparam int DIMMERS_DEF = 6;
  localparam int DIM_IDX_W   = 3;

  localparam logic [15:0] HCT_RESET  = 16'd16667;
  localparam logic [7:0]  LEVEL_FULL = 8'd100;

  localparam logic [2:0] CMD_NOP = 3'd0;
  localparam logic [2:0] CMD_SET = 3'd1;
  localparam logic [2:0] CMD_ON  = 3'd2;
  localparam logic [2:0] CMD_OFF = 3'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NODIM  = 2'd1;
  localparam logic [1:0] STAT_BADID  = 2'd2;
  localparam logic [1:0] STAT_BADCMD = 2'd3;

  localparam logic [1:0] MODE_OFF = 2'd0;
  localparam logic [1:0] MODE_ON  = 2'd1;
  localparam logic [1:0] MODE_DIM = 2'd2;

  // Firing delay as a fraction of 2^16 of a half cycle, indexed by percent.
  localparam logic [15:0] POWER_LUT [0:100] = '{
    16'd65535, 16'd57934, 16'd55907, 16'd54462, 16'd53297,
    16'd52300, 16'd51419, 16'd50621, 16'd49889, 16'd49208,
    16'd48568, 16'd47964, 16'd47390, 16'd46841, 16'd46314,
    16'd45807, 16'd45317, 16'd44842, 16'd44381, 16'd43933,
    16'd43495, 16'd43068, 16'd42650, 16'd42240, 16'd41838,
    16'd41443, 16'd41055, 16'd40672, 16'd40295, 16'd39923,
    16'd39556, 16'd39193, 16'd38834, 16'd38479, 16'd38127,
    16'd37778, 16'd37432, 16'd37089, 16'd36748, 16'd36409,
    16'd36072, 16'd35737, 16'd35403, 16'd35071, 16'd34740,
    16'd34410, 16'd34080, 16'd33752, 16'd33424, 16'd33096,
    16'd32768, 16'd32440, 16'd32112, 16'd31784, 16'd31456,
    16'd31126, 16'd30796, 16'd30465, 16'd30133, 16'd29799,
    16'd29464, 16'd29127, 16'd28788, 16'd28447, 16'd28104,
    16'd27758, 16'd27409, 16'd27057, 16'd26702, 16'd26343,
    16'd25980, 16'd25613, 16'd25241, 16'd24864, 16'd24481,
    16'd24093, 16'd23698, 16'd23296, 16'd22886, 16'd22468,
    16'd22041, 16'd21603, 16'd21155, 16'd20694, 16'd20219,
    16'd19729, 16'd19222, 16'd18695, 16'd18146, 16'd17572,
    16'd16968, 16'd16328, 16'd15647, 16'd14915, 16'd14117,
    16'd13236, 16'd12239, 16'd11074, 16'd9629,  16'd7602,
    16'd0
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic commit;
  } ctl_t;

endpackage

// ===== rtl/triac_dimmer_channel_allocator.sv =====
`timescale 1ns / 1ps
// Triac dimmer channel allocator.
// A command beat (in_cmd, in_unit_id, in_level, in_capture_time) is taken at a
// clock edge where start is high and busy is low. Set level, on and off
// commands each give one result beat on the out_ ports, flagged by out_valid
// for exactly one cycle; a nothing command gives no result.
// The command is captured at the accepting edge, then goes through the calc
// state for the power table multiply and the free-channel search, and the
// commit state that updates the unit and channel state and registers the
// result. busy falls in the cycle in which out_valid is high, so a new command
// can be accepted while the result beat is shown. The sequencer steps one
// command at a time. The user must write half_cycle_ticks through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce it.
// Synchronous reset puts every unit off, frees every channel, drops any
// pending result and loads half_cycle_ticks with 16667.
// The receiver has no back-pressure: it must take each result beat when shown.
module triac_dimmer_channel_allocator #(
  parameter int UNITS   = tdca_pkg::UNITS_DEF,
  parameter int DIMMERS = tdca_pkg::DIMMERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_unit_id,
  input  logic [7:0]  in_level,
  input  logic [15:0] in_capture_time,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [2:0]  out_cmd_echo,
  output logic [7:0]  out_unit_echo,
  output logic [1:0]  out_unit_mode,
  output logic        out_dimmer_valid,
  output logic [2:0]  out_dimmer_index,
  output logic [15:0] out_compare_value,
  output logic        out_fire_pulse
);
  import tdca_pkg::*;

  ctl_t ctl;

  tdca_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  tdca_datapath #(
    .UNITS   (UNITS),
    .DIMMERS (DIMMERS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_unit_id        (in_unit_id),
    .in_level          (in_level),
    .in_capture_time   (in_capture_time),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_cmd_echo      (out_cmd_echo),
    .out_unit_echo     (out_unit_echo),
    .out_unit_mode     (out_unit_mode),
    .out_dimmer_valid  (out_dimmer_valid),
    .out_dimmer_index  (out_dimmer_index),
    .out_compare_value (out_compare_value),
    .out_fire_pulse    (out_fire_pulse)
  );

endmodule

// ===== rtl/tdca_ctrl.sv =====
`timescale 1ns / 1ps
`include "triac_dimmer_channel_allocator_assert.svh"
module tdca_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output tdca_pkg::ctl_t ctl
);
  import tdca_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_CALC;
      end
      S_CALC:   state_nxt = S_COMMIT;
      S_COMMIT: state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      S_CALC:   ctl.calc = 1'b1;
      S_COMMIT: ctl.commit = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  `TDCA_ASSERT_NXT(a_commit_returns_idle, ctl.commit, state_r == S_IDLE, "commit did not end")
  `TDCA_ASSERT_IMP(a_calc_after_load, ctl.calc, $past(ctl.load), "calc without a load")
  `TDCA_ASSERT_NXT(a_accept_starts, start && !busy, ctl.calc, "accepted beat not processed")

endmodule

// ===== rtl/tdca_datapath.sv =====
`timescale 1ns / 1ps
`include "triac_dimmer_channel_allocator_assert.svh"
module tdca_datapath #(
  parameter int UNITS   = tdca_pkg::UNITS_DEF,
  parameter int DIMMERS = tdca_pkg::DIMMERS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  tdca_pkg::ctl_t ctl,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_wdata,
  input  logic [2:0]     in_cmd,
  input  logic [7:0]     in_unit_id,
  input  logic [7:0]     in_level,
  input  logic [15:0]    in_capture_time,
  output logic           out_valid,
  output logic [1:0]     out_status,
  output logic [2:0]     out_cmd_echo,
  output logic [7:0]     out_unit_echo,
  output logic [1:0]     out_unit_mode,
  output logic           out_dimmer_valid,
  output logic [2:0]     out_dimmer_index,
  output logic [15:0]    out_compare_value,
  output logic           out_fire_pulse
);
  import tdca_pkg::*;

  localparam int UIW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int DIW = (DIMMERS > 1) ? $clog2(DIMMERS) : 1;

  logic [15:0] hct_r;

  // Captured command.
  logic [2:0]  cmd_r;
  logic [7:0]  id_r;
  logic [7:0]  lvl_r;
  logic [15:0] cap_r;

  // Results of the multiply and free-channel search.
  logic [15:0]    cv_r;
  logic           free_found_r;
  logic [DIW-1:0] free_idx_r;

  // Unit and channel state.
  logic [1:0]     mode_r  [UNITS];
  logic           has_r   [UNITS];
  logic [DIW-1:0] slot_r  [UNITS];
  logic           busy_r  [DIMMERS];
  logic [6:0]     dlvl_r  [DIMMERS];
  logic [1:0]     mode_nxt[UNITS];
  logic           has_nxt [UNITS];
  logic [DIW-1:0] slot_nxt[UNITS];
  logic           busy_nxt[DIMMERS];
  logic [6:0]     dlvl_nxt[DIMMERS];

  // Result registers.
  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [2:0]  echo_cmd_r;
  logic [7:0]  echo_unit_r;
  logic [1:0]  omode_r;
  logic        odv_r;
  logic [2:0]  oidx_r;
  logic [15:0] ocv_r;
  logic        ofire_r;

  logic        out_valid_nxt;
  logic [1:0]  status_nxt;
  logic [2:0]  echo_cmd_nxt;
  logic [7:0]  echo_unit_nxt;
  logic [1:0]  omode_nxt;
  logic        odv_nxt;
  logic [2:0]  oidx_nxt;
  logic [15:0] ocv_nxt;
  logic        ofire_nxt;

  logic [6:0]  lut_idx;
  logic [31:0] prod;
  logic        found;
  logic [DIW-1:0] found_idx;

  // Only levels 1 to 99 ever use the product, so other levels look up entry 0.
  assign lut_idx = (lvl_r < LEVEL_FULL) ? lvl_r[6:0] : 7'd0;
  assign prod    = {16'd0, POWER_LUT[lut_idx]} * {16'd0, hct_r};

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = DIMMERS - 1; k >= 0; k--) begin
      if (!busy_r[k]) begin
        found     = 1'b1;
        found_idx = DIW'(k);
      end
    end
  end

  always_comb begin
    logic [UIW-1:0] u;
    logic [DIW-1:0] s;
    logic           id_ok;
    logic           full;
    logic           zero;

    u     = UIW'(id_r - 8'd1);
    s     = slot_r[u];
    id_ok = (id_r != 8'd0) && (id_r <= 8'(UNITS));
    full  = (cmd_r == CMD_ON) || ((cmd_r == CMD_SET) && (lvl_r >= LEVEL_FULL));
    zero  = (cmd_r == CMD_OFF) || ((cmd_r == CMD_SET) && (lvl_r == 8'd0));

    mode_nxt = mode_r;
    has_nxt  = has_r;
    slot_nxt = slot_r;
    busy_nxt = busy_r;
    dlvl_nxt = dlvl_r;

    out_valid_nxt = 1'b0;
    status_nxt    = STAT_OK;
    echo_cmd_nxt  = cmd_r;
    echo_unit_nxt = 8'd0;
    omode_nxt     = MODE_OFF;
    odv_nxt       = 1'b0;
    oidx_nxt      = 3'd0;
    ocv_nxt       = 16'd0;
    ofire_nxt     = 1'b0;

    if (ctl.commit) begin
      case (cmd_r)
        CMD_NOP: out_valid_nxt = 1'b0;
        CMD_SET, CMD_ON, CMD_OFF: begin
          out_valid_nxt = 1'b1;
          echo_unit_nxt = id_r;
          if (!id_ok) begin
            status_nxt = STAT_BADID;
          end else if (full || zero) begin
            if (has_r[u]) begin
              busy_nxt[s] = 1'b0;
              dlvl_nxt[s] = 7'd0;
            end
            has_nxt[u]  = 1'b0;
            slot_nxt[u] = '0;
            mode_nxt[u] = full ? MODE_ON : MODE_OFF;
            omode_nxt   = full ? MODE_ON : MODE_OFF;
          end else if (has_r[u]) begin
            ofire_nxt   = (lvl_r > {1'b0, dlvl_r[s]}) && (cap_r >= cv_r);
            dlvl_nxt[s] = lvl_r[6:0];
            omode_nxt   = mode_r[u];
            odv_nxt     = 1'b1;
            oidx_nxt    = 3'(s);
            ocv_nxt     = cv_r;
          end else if (free_found_r) begin
            busy_nxt[free_idx_r] = 1'b1;
            dlvl_nxt[free_idx_r] = lvl_r[6:0];
            has_nxt[u]  = 1'b1;
            slot_nxt[u] = free_idx_r;
            mode_nxt[u] = MODE_DIM;
            omode_nxt   = MODE_DIM;
            odv_nxt     = 1'b1;
            oidx_nxt    = 3'(free_idx_r);
            ocv_nxt     = cv_r;
          end else begin
            status_nxt = STAT_NODIM;
            omode_nxt  = mode_r[u];
          end
        end
        default: begin
          out_valid_nxt = 1'b1;
          status_nxt    = STAT_BADCMD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hct_r       <= HCT_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < UNITS; i++) begin
        mode_r[i] <= MODE_OFF;
        has_r[i]  <= 1'b0;
        slot_r[i] <= '0;
      end
      for (int k = 0; k < DIMMERS; k++) begin
        busy_r[k] <= 1'b0;
        dlvl_r[k] <= 7'd0;
      end
    end else begin
      if (cfg_we) hct_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
      mode_r <= mode_nxt;
      has_r  <= has_nxt;
      slot_r <= slot_nxt;
      busy_r <= busy_nxt;
      dlvl_r <= dlvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      id_r  <= in_unit_id;
      lvl_r <= in_level;
      cap_r <= in_capture_time;
    end
    if (ctl.calc) begin
      cv_r         <= prod[31:16];
      free_found_r <= found;
      free_idx_r   <= found_idx;
    end
    if (ctl.commit) begin
      status_r    <= status_nxt;
      echo_cmd_r  <= echo_cmd_nxt;
      echo_unit_r <= echo_unit_nxt;
      omode_r     <= omode_nxt;
      odv_r       <= odv_nxt;
      oidx_r      <= oidx_nxt;
      ocv_r       <= ocv_nxt;
      ofire_r     <= ofire_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_cmd_echo      = echo_cmd_r;
  assign out_unit_echo     = echo_unit_r;
  assign out_unit_mode     = omode_r;
  assign out_dimmer_valid  = odv_r;
  assign out_dimmer_index  = oidx_r;
  assign out_compare_value = ocv_r;
  assign out_fire_pulse    = ofire_r;

  `TDCA_ASSERT_IMP(a_strobe_after_commit, out_valid_r, $past(ctl.commit), "stray result strobe")
  `TDCA_ASSERT_IMP(a_dimmer_means_dim, out_valid_r && odv_r, omode_r == MODE_DIM, "dimmer without dim mode")
  `TDCA_ASSERT_IMP(a_error_is_quiet, out_valid_r && (status_r != STAT_OK), !ofire_r && !odv_r, "error result carries a channel")

endmodule

// ===== test/tb_triac_dimmer_channel_allocator.sv =====
`timescale 1ns / 1ps
module tb_triac_dimmer_channel_allocator;
  import tdca_pkg::*;

  localparam int NUM_UNITS     = UNITS_DEF;
  localparam int NUM_DIMMERS   = DIMMERS_DEF;
  localparam int ITEM_TARGET   = 700;
  localparam int RANDOM_PHASES = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_LIMIT  = 100;

  localparam logic [2:0] CMD_INVALID_FIRST = 3'd4;
  localparam logic [2:0] CMD_INVALID_LAST  = 3'd7;

  // Firing delay as a fraction of 2^16 of a half cycle, indexed by percent.
  localparam logic [15:0] FIRE_DELAY_FRAC [0:100] = '{
    16'd65535, 16'd57934, 16'd55907, 16'd54462, 16'd53297,
    16'd52300, 16'd51419, 16'd50621, 16'd49889, 16'd49208,
    16'd48568, 16'd47964, 16'd47390, 16'd46841, 16'd46314,
    16'd45807, 16'd45317, 16'd44842, 16'd44381, 16'd43933,
    16'd43495, 16'd43068, 16'd42650, 16'd42240, 16'd41838,
    16'd41443, 16'd41055, 16'd40672, 16'd40295, 16'd39923,
    16'd39556, 16'd39193, 16'd38834, 16'd38479, 16'd38127,
    16'd37778, 16'd37432, 16'd37089, 16'd36748, 16'd36409,
    16'd36072, 16'd35737, 16'd35403, 16'd35071, 16'd34740,
    16'd34410, 16'd34080, 16'd33752, 16'd33424, 16'd33096,
    16'd32768, 16'd32440, 16'd32112, 16'd31784, 16'd31456,
    16'd31126, 16'd30796, 16'd30465, 16'd30133, 16'd29799,
    16'd29464, 16'd29127, 16'd28788, 16'd28447, 16'd28104,
    16'd27758, 16'd27409, 16'd27057, 16'd26702, 16'd26343,
    16'd25980, 16'd25613, 16'd25241, 16'd24864, 16'd24481,
    16'd24093, 16'd23698, 16'd23296, 16'd22886, 16'd22468,
    16'd22041, 16'd21603, 16'd21155, 16'd20694, 16'd20219,
    16'd19729, 16'd19222, 16'd18695, 16'd18146, 16'd17572,
    16'd16968, 16'd16328, 16'd15647, 16'd14915, 16'd14117,
    16'd13236, 16'd12239, 16'd11074, 16'd9629,  16'd7602,
    16'd0
  };

  typedef struct {
    logic [1:0]  status;
    logic [2:0]  cmd;
    logic [7:0]  unit;
    logic [1:0]  mode;
    logic        holds;
    logic [2:0]  slot;
    logic [15:0] compare;
    logic        fire;
  } answer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = CMD_NOP;
  logic [7:0]  in_unit_id = '0;
  logic [7:0]  in_level = '0;
  logic [15:0] in_capture_time = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [2:0]  out_cmd_echo;
  logic [7:0]  out_unit_echo;
  logic [1:0]  out_unit_mode;
  logic        out_dimmer_valid;
  logic [2:0]  out_dimmer_index;
  logic [15:0] out_compare_value;
  logic        out_fire_pulse;

  // Allocator state as the testbench tracks it.
  logic [15:0] ticks_per_half;
  logic [1:0]  mode_of_unit [NUM_UNITS];
  logic        unit_holds   [NUM_UNITS];
  logic [2:0]  slot_of_unit [NUM_UNITS];
  logic        slot_taken   [NUM_DIMMERS];
  logic [6:0]  slot_level   [NUM_DIMMERS];
  logic [15:0] slot_compare [NUM_DIMMERS];
  answer_t     pending_answers [$];

  logic idle_bursts = 1'b0;
  int   commands_sent = 0;
  int   answered_commands = 0;
  int   answers_checked = 0;
  int   pulses_seen = 0;
  int   ticks_settings = 1;
  int   mismatches = 0;
  int   cycles = 0;

  triac_dimmer_channel_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .start             (start),
    .busy              (busy),
    .in_cmd            (in_cmd),
    .in_unit_id        (in_unit_id),
    .in_level          (in_level),
    .in_capture_time   (in_capture_time),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_cmd_echo      (out_cmd_echo),
    .out_unit_echo     (out_unit_echo),
    .out_unit_mode     (out_unit_mode),
    .out_dimmer_valid  (out_dimmer_valid),
    .out_dimmer_index  (out_dimmer_index),
    .out_compare_value (out_compare_value),
    .out_fire_pulse    (out_fire_pulse)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d answers outstanding", cycles,
               pending_answers.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void clear_allocator();
    ticks_per_half = HCT_RESET;
    for (int u = 0; u < NUM_UNITS; u++) begin
      mode_of_unit[u] = MODE_OFF;
      unit_holds[u]   = 1'b0;
      slot_of_unit[u] = '0;
    end
    for (int d = 0; d < NUM_DIMMERS; d++) begin
      slot_taken[d]   = 1'b0;
      slot_level[d]   = '0;
      slot_compare[d] = '0;
    end
  endfunction

  function automatic logic [15:0] compare_for(input int pct);
    logic [31:0] prod;
    prod = 32'(FIRE_DELAY_FRAC[pct]) * 32'(ticks_per_half);
    return prod[31:16];
  endfunction

  // A released channel goes back to level 0 but keeps its compare value.
  function automatic void release_slot(input int u);
    if (unit_holds[u]) begin
      slot_taken[slot_of_unit[u]] = 1'b0;
      slot_level[slot_of_unit[u]] = '0;
    end
    unit_holds[u]   = 1'b0;
    slot_of_unit[u] = '0;
  endfunction

  function automatic void apply_command(input logic [2:0] cmd, input logic [7:0] id,
                                        input logic [7:0] lvl, input logic [15:0] cap);
    answer_t     ans;
    int          u;
    int          d;
    int          pct;
    logic [15:0] cv;
    ans = '{default: '0};
    if (cmd == CMD_NOP) return;
    ans.cmd = cmd;
    if (cmd > CMD_OFF) begin
      ans.status = STAT_BADCMD;
      pending_answers.push_back(ans);
      return;
    end
    ans.unit = id;
    if (id == 0 || id > NUM_UNITS) begin
      ans.status = STAT_BADID;
      pending_answers.push_back(ans);
      return;
    end
    u = id - 1;
    pct = (cmd == CMD_ON) ? 100 : (cmd == CMD_OFF) ? 0 : int'(lvl);
    ans.status = STAT_OK;
    if (pct >= 100) begin
      release_slot(u);
      mode_of_unit[u] = MODE_ON;
    end else if (pct == 0) begin
      release_slot(u);
      mode_of_unit[u] = MODE_OFF;
    end else begin
      cv = compare_for(pct);
      if (unit_holds[u]) begin
        d = slot_of_unit[u];
        ans.fire = (pct > slot_level[d]) && (cap >= cv);
        slot_level[d]   = 7'(pct);
        slot_compare[d] = cv;
      end else begin
        d = -1;
        for (int k = NUM_DIMMERS - 1; k >= 0; k--) begin
          if (!slot_taken[k]) d = k;
        end
        if (d < 0) begin
          ans.status = STAT_NODIM;
        end else begin
          slot_taken[d]   = 1'b1;
          slot_level[d]   = 7'(pct);
          slot_compare[d] = cv;
          unit_holds[u]   = 1'b1;
          slot_of_unit[u] = 3'(d);
          mode_of_unit[u] = MODE_DIM;
        end
      end
    end
    ans.mode = mode_of_unit[u];
    if (unit_holds[u]) begin
      ans.holds   = 1'b1;
      ans.slot    = slot_of_unit[u];
      ans.compare = slot_compare[slot_of_unit[u]];
    end
    pending_answers.push_back(ans);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display("[%0t] mismatch on %s after %0d answers: got %0h, expected %0h",
               $realtime, what, answers_checked, got, want);
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : result_checker
    answer_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result beat with no command outstanding", '0, '0);
      end else begin
        want = pending_answers.pop_front();
        check_field("status", 16'(out_status), 16'(want.status));
        check_field("cmd_echo", 16'(out_cmd_echo), 16'(want.cmd));
        check_field("unit_echo", 16'(out_unit_echo), 16'(want.unit));
        check_field("unit_mode", 16'(out_unit_mode), 16'(want.mode));
        check_field("dimmer_valid", 16'(out_dimmer_valid), 16'(want.holds));
        check_field("dimmer_index", 16'(out_dimmer_index), 16'(want.slot));
        check_field("compare_value", out_compare_value, want.compare);
        check_field("fire_pulse", 16'(out_fire_pulse), 16'(want.fire));
        answers_checked++;
        if (want.fire) pulses_seen++;
      end
    end
  end

  // Called at a rising edge; returns at the edge that took the beat, or after
  // an idle burst. start stays high when another beat follows at once.
  task automatic send_command(input logic [2:0] cmd, input logic [7:0] id,
                              input logic [7:0] lvl, input logic [15:0] cap);
    in_cmd          <= cmd;
    in_unit_id      <= id;
    in_level        <= lvl;
    in_capture_time <= cap;
    start           <= 1'b1;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    apply_command(cmd, id, lvl, cap);
    commands_sent++;
    if (cmd != CMD_NOP) answered_commands++;
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // A nothing command gives no answer, so the block may still be working on
  // one after the queue drains; the settle time covers its latency.
  task automatic wait_idle();
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_half_cycle_ticks(input logic [15:0] ticks);
    wait_idle();
    cfg_wdata <= ticks;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    ticks_per_half = ticks;
    ticks_settings++;
  endtask

  task automatic test_invalid_requests();
    send_command(CMD_NOP, 8'd1, 8'd50, 16'd0);
    for (int c = CMD_INVALID_FIRST; c <= CMD_INVALID_LAST; c++)
      send_command(3'(c), 8'($urandom_range(0, 255)), 8'hFF, 16'hFFFF);
    send_command(CMD_SET, 8'd0, 8'd50, 16'd0);
    send_command(CMD_ON, 8'(NUM_UNITS + 1), 8'd0, 16'd0);
    send_command(CMD_OFF, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_dimming_and_release();
    send_command(CMD_SET, 8'd1, 8'd1, 16'd0);
    send_command(CMD_SET, 8'd2, 8'd99, 16'hFFFF);
    send_command(CMD_SET, 8'd1, 8'd50, 16'hFFFF);
    send_command(CMD_SET, 8'd1, 8'd40, 16'hFFFF);
    send_command(CMD_SET, 8'd3, 8'd10, 16'd0);
    // Off must ignore the level and free the lowest channel for the next taker.
    send_command(CMD_OFF, 8'd1, 8'd77, 16'd0);
    send_command(CMD_SET, 8'd1, 8'd20, 16'd0);
    send_command(CMD_SET, 8'd1, 8'd100, 16'd0);
    send_command(CMD_SET, 8'd2, 8'd255, 16'd0);
    send_command(CMD_ON, 8'd3, 8'd5, 16'd0);
    send_command(CMD_SET, 8'd3, 8'd0, 16'hFFFF);
    send_command(CMD_OFF, 8'd2, 8'd0, 16'd0);
  endtask

  task automatic test_early_pulse();
    send_command(CMD_SET, 8'd2, 8'd5, 16'hFFFF);
    send_command(CMD_SET, 8'd2, 8'd6, compare_for(6) - 16'd1);
    send_command(CMD_SET, 8'd2, 8'd7, compare_for(7));
    send_command(CMD_SET, 8'd2, 8'd99, 16'hFFFF);
  endtask

  task automatic test_random_traffic();
    logic [15:0] ticks;
    logic [2:0]  cmd;
    logic [7:0]  id;
    logic [7:0]  lvl;
    logic [15:0] cap;
    logic [15:0] near;
    int          goal;
    int          r;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: ticks = 16'd1;
        1: ticks = 16'hFFFF;
        3: ticks = HCT_RESET;
        default: ticks = 16'($urandom_range(2, 65534));
      endcase
      set_half_cycle_ticks(ticks);
      goal = answered_commands + ITEM_TARGET / RANDOM_PHASES;
      while (answered_commands < goal) begin
        // Idling switches on and off in stretches; the last phase runs flat out.
        if (commands_sent % 20 == 0 || phase == RANDOM_PHASES - 1)
          idle_bursts = (phase < RANDOM_PHASES - 1) && ($urandom_range(0, 2) != 0);
        r = $urandom_range(0, 99);
        if (r < 6) cmd = CMD_NOP;
        else if (r < 70) cmd = CMD_SET;
        else if (r < 80) cmd = CMD_ON;
        else if (r < 90) cmd = CMD_OFF;
        else cmd = 3'($urandom_range(CMD_INVALID_FIRST, CMD_INVALID_LAST));
        r = $urandom_range(0, 99);
        id = (r < 88) ? 8'($urandom_range(1, NUM_UNITS)) : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 75) lvl = 8'($urandom_range(1, 99));
        else if (r < 83) lvl = 8'd0;
        else if (r < 91) lvl = 8'd100;
        else lvl = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 30 && lvl >= 1 && lvl <= 99) begin
          // Land on or next to the compare value to work the pulse threshold.
          near = compare_for(int'(lvl));
          cap = ($urandom_range(0, 1) == 1) ? near + 16'($urandom_range(0, 2))
                                            : near - 16'($urandom_range(0, 2));
        end else if (r < 40) begin
          cap = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'd0;
        end else begin
          cap = 16'($urandom_range(0, 65535));
        end
        send_command(cmd, id, lvl, cap);
      end
    end
  endtask

  initial begin
    clear_allocator();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_invalid_requests();
    test_dimming_and_release();
    test_early_pulse();
    test_random_traffic();
    wait_idle();
    $display("Sent %0d commands, checked %0d answers (%0d early pulses) across %0d",
             commands_sent, answers_checked, pulses_seen, ticks_settings);
    $display("half-cycle settings including 1 and 65535; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tdca_pkg.sv
rtl/tdca_ctrl.sv
rtl/tdca_datapath.sv
rtl/triac_dimmer_channel_allocator.sv
test/tb_triac_dimmer_channel_allocator.sv
